@@ rtl/mclm_pkg.sv @@
// ----------------------------------------------------------------------------
// mclm_pkg
// Shared types and constants of the mutex and condition lock manager.
// ----------------------------------------------------------------------------
package mclm_pkg;

    localparam int MUTEX_SLOTS = 1024;
    localparam int COND_SLOTS  = 64;
    localparam int WAITER_POOL = 32;
    localparam int RESULT_CAP  = 33;

    localparam int SLOT_W  = $clog2(MUTEX_SLOTS);
    localparam int SLOT_CW = $clog2(MUTEX_SLOTS + 1);
    localparam int COND_W  = $clog2(COND_SLOTS);
    localparam int POOL_W  = $clog2(WAITER_POOL);
    localparam int PLACE_W = $clog2(MUTEX_SLOTS + COND_SLOTS);
    localparam int CNT_W   = $clog2(RESULT_CAP + 1);

    localparam logic [2:0] KIND_LOCK      = 3'd0;
    localparam logic [2:0] KIND_UNLOCK    = 3'd1;
    localparam logic [2:0] KIND_WAIT      = 3'd2;
    localparam logic [2:0] KIND_BROADCAST = 3'd3;
    localparam logic [2:0] KIND_CANCEL    = 3'd4;
    localparam logic [2:0] KIND_EXIT      = 3'd5;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_INVALID       = 3'd1;
    localparam logic [2:0] ST_NOT_PERMITTED = 3'd2;
    localparam logic [2:0] ST_INTERRUPTED   = 3'd3;
    localparam logic [2:0] ST_NO_ROOM       = 3'd4;
    localparam logic [2:0] ST_QUEUED        = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        process;
        logic signed [31:0] mutex_key;
        logic signed [31:0] cond_key;
    } mclm_req_t;

    typedef struct packed {
        logic [15:0] dest_process;
        logic [2:0]  status;
        logic        last;
    } mclm_rsp_t;

    typedef struct packed {
        logic        used;
        logic [31:0] key;
        logic [15:0] holder;
    } mclm_slot_t;

endpackage

@@ rtl/mutex_condvar_lock_manager.sv @@
// ----------------------------------------------------------------------------
// mutex_condvar_lock_manager
// Sequential lock manager for mutexes and condition variables.
// ----------------------------------------------------------------------------
// Requests arrive as one word on the req channel (req_valid, req_stall, req)
// and replies and grants leave as words on the rsp channel (rsp_valid,
// rsp_stall, rsp). Each request yields zero to 33 words; the final one has
// last set. One request is handled at a time; req_stall is low only while
// the block is idle.
// The mutex table sits in a single-port memory that is walked one slot per
// cycle, and a walk stops at its first match. A permitted unlock adds a
// pool walk, and a wait adds a condition table walk on top of an unlock. A
// broadcast costs the condition table, one table walk and one pool walk per
// parked waiter, and a final pool walk. A cancel costs one table walk and two
// pool walks; an exit costs a pool walk, one table walk and a pool walk per
// held mutex.
// After reset the block clears the mutex table and holds req_stall high
// meanwhile.
// While rsp_stall is high the output word holds, one more result waits
// inside, and the engine waits once a third result is ready; nothing is lost.
// ----------------------------------------------------------------------------
module mutex_condvar_lock_manager
    import mclm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  mclm_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output mclm_rsp_t rsp
);

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISP     = 5'd2;
    localparam logic [4:0] S_SCAN     = 5'd3;
    localparam logic [4:0] S_OSCAN    = 5'd4;
    localparam logic [4:0] S_EMIT     = 5'd5;
    localparam logic [4:0] S_FIN      = 5'd6;
    localparam logic [4:0] S_LK_EVAL  = 5'd7;
    localparam logic [4:0] S_K0_POST  = 5'd8;
    localparam logic [4:0] S_UL_EVAL  = 5'd9;
    localparam logic [4:0] S_UL_REL   = 5'd10;
    localparam logic [4:0] S_K1_POST  = 5'd11;
    localparam logic [4:0] S_K2_POST  = 5'd12;
    localparam logic [4:0] S_CS_RD    = 5'd13;
    localparam logic [4:0] S_CS_CHK   = 5'd14;
    localparam logic [4:0] S_K2_COND  = 5'd15;
    localparam logic [4:0] S_K3_START = 5'd16;
    localparam logic [4:0] S_K3_LOOP  = 5'd17;
    localparam logic [4:0] S_K3_GOT   = 5'd18;
    localparam logic [4:0] S_K3_POST  = 5'd19;
    localparam logic [4:0] S_K4_POOL  = 5'd20;
    localparam logic [4:0] S_K4_PARK  = 5'd21;
    localparam logic [4:0] S_SWEEP    = 5'd22;
    localparam logic [4:0] S_K4_POST  = 5'd23;
    localparam logic [4:0] S_EX_HIT   = 5'd24;
    localparam logic [4:0] S_EX_NEXT  = 5'd25;

    localparam logic [SLOT_CW-1:0] SLOT_END  = SLOT_CW'(MUTEX_SLOTS);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(MUTEX_SLOTS - 1);
    localparam logic [COND_W-1:0]  COND_LAST = COND_W'(COND_SLOTS - 1);
    localparam logic [POOL_W-1:0]  POOL_LAST = POOL_W'(WAITER_POOL - 1);
    localparam logic [PLACE_W-1:0] COND_BASE = PLACE_W'(MUTEX_SLOTS);

    mclm_slot_t mtab [MUTEX_SLOTS];
    logic [31:0] ctab [COND_SLOTS];
    logic [15:0] pool_proc_reg  [WAITER_POOL];
    logic [31:0] pool_lock_reg  [WAITER_POOL];
    logic [PLACE_W-1:0] pool_place_reg [WAITER_POOL];
    logic [31:0] pool_stamp_reg [WAITER_POOL];

    logic [4:0] st_reg, st_next, ret_reg, ret_next, lk_ret_reg, lk_ret_next;
    logic [4:0] em_ret_reg, em_ret_next;
    logic [2:0] kind_reg, kind_next;
    logic [15:0] proc_reg, proc_next, lk_proc_reg, lk_proc_next;
    logic [31:0] mkey_reg, mkey_next, ckey_reg, ckey_next, lk_key_reg, lk_key_next;
    logic reuse_vld_reg, reuse_vld_next;
    logic [POOL_W-1:0] reuse_idx_reg, reuse_idx_next;
    logic [2:0] lk_res_reg, lk_res_next, ul_res_reg, ul_res_next;
    logic f_hit_reg, f_hit_next, f_free_vld_reg, f_free_vld_next;
    logic [SLOT_W-1:0] f_slot_reg, f_slot_next, f_free_reg, f_free_next;
    logic [31:0] f_key_reg, f_key_next;
    logic [15:0] f_holder_reg, f_holder_next;
    logic [SLOT_CW-1:0] sc_ctr_reg, sc_ctr_next;
    logic chk_vld_reg, chk_vld_next, sc_holder_reg, sc_holder_next;
    logic [SLOT_W-1:0] chk_addr_reg, chk_addr_next;
    logic [POOL_W-1:0] op_ptr_reg, op_ptr_next, ob_idx_reg, ob_idx_next;
    logic ob_hit_reg, ob_hit_next, oq_cancel_reg, oq_cancel_next;
    logic [PLACE_W-1:0] ob_place_reg, ob_place_next, oq_place_reg, oq_place_next;
    logic [31:0] ob_age_reg, ob_age_next;
    logic [COND_W-1:0] cs_ptr_reg, cs_ptr_next, c_idx_reg, c_idx_next;
    logic c_found_reg, c_found_next, hit_reg, hit_next;
    logic [COND_SLOTS-1:0] sw_mask_reg, sw_mask_next, cuse_reg, cuse_next;
    logic [15:0] em_dest_reg, em_dest_next, pend_dest_reg, pend_dest_next;
    logic [2:0] em_st_reg, em_st_next, pend_st_reg, pend_st_next;
    logic pend_vld_reg, pend_vld_next, out_vld_reg, out_vld_next;
    logic [CNT_W-1:0] n_reg, n_next;
    mclm_rsp_t out_reg, out_next;
    logic [WAITER_POOL-1:0] pv_reg, pv_next;
    logic [31:0] count_reg, count_next;

    mclm_slot_t mrd_reg;
    logic [31:0] crd_reg;
    logic mw_en, mr_en, cw_en, cr_en, pool_put, push, push_last, out_free;
    logic [SLOT_W-1:0] mw_addr;
    mclm_slot_t mw_data;
    logic [COND_W-1:0] cw_addr;
    logic [POOL_W-1:0] put_idx, p_ra, pf_idx;
    logic [15:0] put_proc;
    logic [31:0] put_lock;
    logic [PLACE_W-1:0] put_place, p_place, place_off;
    logic [WAITER_POOL-1:0] pclr, pm_cancel, pm_exit;
    logic p_v, p_match, p_better, pf_vld, cf_vld;
    logic [15:0] p_proc;
    logic [31:0] p_age;
    logic [COND_W-1:0] cf_idx;
    logic [4:0] ul_post;

    assign req_stall = (st_reg != S_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp = out_reg;
    assign out_free = !out_vld_reg || !rsp_stall;

    assign p_ra = (st_reg == S_OSCAN || st_reg == S_SWEEP) ? op_ptr_reg : ob_idx_reg;
    assign p_v = pv_reg[p_ra];
    assign p_proc = pool_proc_reg[p_ra];
    assign p_place = pool_place_reg[p_ra];
    assign p_age = count_reg - pool_stamp_reg[p_ra];
    assign place_off = p_place - COND_BASE;
    assign p_match = p_v && (oq_cancel_reg ?
        (p_proc == proc_reg && p_place >= COND_BASE) : (p_place == oq_place_reg));
    assign p_better = !ob_hit_reg || p_place < ob_place_reg ||
        (p_place == ob_place_reg && p_age > ob_age_reg);
    assign ul_post = (kind_reg == KIND_UNLOCK) ? S_K1_POST :
        (kind_reg == KIND_WAIT) ? S_K2_POST : S_EX_NEXT;

    always_comb
    begin
        pf_vld = 1'b0;
        pf_idx = '0;
        for (int w = WAITER_POOL - 1; w >= 0; w--)
        begin
            if (!pv_reg[w])
            begin
                pf_vld = 1'b1;
                pf_idx = POOL_W'(w);
            end
        end
        cf_vld = 1'b0;
        cf_idx = '0;
        for (int c = COND_SLOTS - 1; c >= 0; c--)
        begin
            if (!cuse_reg[c])
            begin
                cf_vld = 1'b1;
                cf_idx = COND_W'(c);
            end
        end
        for (int w = 0; w < WAITER_POOL; w++)
        begin
            pm_exit[w] = pv_reg[w] && pool_proc_reg[w] == proc_reg;
            pm_cancel[w] = pm_exit[w] && pool_place_reg[w] < COND_BASE;
        end
    end

    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg; lk_ret_next = lk_ret_reg;
        em_ret_next = em_ret_reg; kind_next = kind_reg; proc_next = proc_reg;
        mkey_next = mkey_reg; ckey_next = ckey_reg; lk_proc_next = lk_proc_reg;
        lk_key_next = lk_key_reg; reuse_vld_next = reuse_vld_reg;
        reuse_idx_next = reuse_idx_reg; lk_res_next = lk_res_reg; ul_res_next = ul_res_reg;
        f_hit_next = f_hit_reg; f_free_vld_next = f_free_vld_reg; f_slot_next = f_slot_reg;
        f_free_next = f_free_reg; f_key_next = f_key_reg; f_holder_next = f_holder_reg;
        sc_ctr_next = sc_ctr_reg; chk_vld_next = chk_vld_reg; sc_holder_next = sc_holder_reg;
        chk_addr_next = chk_addr_reg; op_ptr_next = op_ptr_reg; ob_idx_next = ob_idx_reg;
        ob_hit_next = ob_hit_reg; oq_cancel_next = oq_cancel_reg;
        ob_place_next = ob_place_reg; oq_place_next = oq_place_reg; ob_age_next = ob_age_reg;
        cs_ptr_next = cs_ptr_reg; c_idx_next = c_idx_reg; c_found_next = c_found_reg;
        hit_next = hit_reg; sw_mask_next = sw_mask_reg; cuse_next = cuse_reg;
        em_dest_next = em_dest_reg; em_st_next = em_st_reg; pend_dest_next = pend_dest_reg;
        pend_st_next = pend_st_reg; pend_vld_next = pend_vld_reg; n_next = n_reg;
        count_next = count_reg; out_next = out_reg;
        out_vld_next = out_vld_reg && rsp_stall;
        mw_en = 1'b0; mw_addr = f_slot_reg; mw_data = '0;
        mr_en = 1'b0; cw_en = 1'b0; cw_addr = c_idx_reg; cr_en = 1'b0;
        pool_put = 1'b0; put_idx = pf_idx; put_proc = proc_reg; put_lock = mkey_reg;
        put_place = '0; pclr = '0; push = 1'b0; push_last = 1'b0;

        case (st_reg)
            S_CLR:
            begin
                mw_en = 1'b1;
                mw_addr = sc_ctr_reg[SLOT_W-1:0];
                sc_ctr_next = sc_ctr_reg + 1'b1;
                if (sc_ctr_reg[SLOT_W-1:0] == SLOT_LAST)
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    proc_next = req.process;
                    mkey_next = req.mutex_key;
                    ckey_next = req.cond_key;
                    n_next = '0;
                    st_next = S_DISP;
                end
            end
            S_DISP:
            begin
                sc_ctr_next = '0;
                chk_vld_next = 1'b0;
                f_hit_next = 1'b0;
                f_free_vld_next = 1'b0;
                sc_holder_next = 1'b0;
                lk_proc_next = proc_reg;
                lk_key_next = mkey_reg;
                reuse_vld_next = 1'b0;
                hit_next = 1'b0;
                case (kind_reg)
                    KIND_LOCK:
                    begin
                        ret_next = S_LK_EVAL;
                        lk_ret_next = S_K0_POST;
                        st_next = S_SCAN;
                    end
                    KIND_UNLOCK, KIND_WAIT:
                    begin
                        ret_next = S_UL_EVAL;
                        st_next = S_SCAN;
                    end
                    KIND_BROADCAST:
                    begin
                        cs_ptr_next = '0;
                        c_found_next = 1'b0;
                        st_next = S_CS_RD;
                    end
                    KIND_CANCEL:
                    begin
                        sc_holder_next = 1'b1;
                        ret_next = S_K4_POOL;
                        st_next = S_SCAN;
                    end
                    KIND_EXIT:
                    begin
                        pclr = pm_exit;
                        op_ptr_next = '0;
                        sw_mask_next = '0;
                        st_next = S_SWEEP;
                    end
                    default:
                    begin
                        em_dest_next = proc_reg;
                        em_st_next = ST_INVALID;
                        em_ret_next = S_FIN;
                        st_next = S_EMIT;
                    end
                endcase
            end
            S_SCAN:
            begin
                mr_en = (sc_ctr_reg < SLOT_END);
                chk_vld_next = mr_en;
                chk_addr_next = sc_ctr_reg[SLOT_W-1:0];
                if (mr_en)
                begin
                    sc_ctr_next = sc_ctr_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (mrd_reg.used && (sc_holder_reg ? (mrd_reg.holder == proc_reg) :
                        (mrd_reg.key == lk_key_reg)))
                    begin
                        f_hit_next = 1'b1;
                        f_slot_next = chk_addr_reg;
                        f_key_next = mrd_reg.key;
                        f_holder_next = mrd_reg.holder;
                        chk_vld_next = 1'b0;
                        st_next = ret_reg;
                    end
                    else
                    begin
                        if (!mrd_reg.used && !f_free_vld_reg)
                        begin
                            f_free_vld_next = 1'b1;
                            f_free_next = chk_addr_reg;
                        end
                        if (chk_addr_reg == SLOT_LAST)
                        begin
                            chk_vld_next = 1'b0;
                            st_next = ret_reg;
                        end
                    end
                end
            end
            S_OSCAN:
            begin
                if (p_match && p_better)
                begin
                    ob_hit_next = 1'b1;
                    ob_idx_next = op_ptr_reg;
                    ob_place_next = p_place;
                    ob_age_next = p_age;
                end
                op_ptr_next = op_ptr_reg + 1'b1;
                if (op_ptr_reg == POOL_LAST)
                begin
                    st_next = ret_reg;
                end
            end
            S_EMIT:
            begin
                if (n_reg >= CNT_W'(RESULT_CAP))
                begin
                    st_next = em_ret_reg;
                end
                else if (!pend_vld_reg || out_free)
                begin
                    push = pend_vld_reg;
                    pend_vld_next = 1'b1;
                    pend_dest_next = em_dest_reg;
                    pend_st_next = em_st_reg;
                    n_next = n_reg + 1'b1;
                    st_next = em_ret_reg;
                end
            end
            S_FIN:
            begin
                if (!pend_vld_reg)
                begin
                    st_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push = 1'b1;
                    push_last = 1'b1;
                    pend_vld_next = 1'b0;
                    st_next = S_IDLE;
                end
            end
            S_LK_EVAL:
            begin
                st_next = lk_ret_reg;
                if (f_hit_reg && f_holder_reg == lk_proc_reg)
                begin
                    pclr[reuse_idx_reg] = reuse_vld_reg;
                    lk_res_next = ST_INVALID;
                end
                else if (f_hit_reg)
                begin
                    if (!reuse_vld_reg && !pf_vld)
                    begin
                        lk_res_next = ST_NO_ROOM;
                    end
                    else
                    begin
                        pool_put = 1'b1;
                        put_idx = reuse_vld_reg ? reuse_idx_reg : pf_idx;
                        put_proc = lk_proc_reg;
                        put_lock = lk_key_reg;
                        put_place = PLACE_W'(f_slot_reg);
                        count_next = count_reg + 1'b1;
                        lk_res_next = ST_QUEUED;
                    end
                end
                else
                begin
                    pclr[reuse_idx_reg] = reuse_vld_reg;
                    if (f_free_vld_reg)
                    begin
                        mw_en = 1'b1;
                        mw_addr = f_free_reg;
                        mw_data = '{used: 1'b1, key: lk_key_reg, holder: lk_proc_reg};
                        lk_res_next = ST_OK;
                    end
                    else
                    begin
                        lk_res_next = ST_INVALID;
                    end
                end
            end
            S_K0_POST:
            begin
                if (lk_res_reg != ST_QUEUED)
                begin
                    em_dest_next = proc_reg;
                    em_st_next = lk_res_reg;
                    em_ret_next = S_FIN;
                    st_next = S_EMIT;
                end
                else
                begin
                    st_next = S_FIN;
                end
            end
            S_UL_EVAL:
            begin
                if (!f_hit_reg || f_holder_reg != proc_reg)
                begin
                    ul_res_next = ST_NOT_PERMITTED;
                    st_next = ul_post;
                end
                else
                begin
                    op_ptr_next = '0;
                    ob_hit_next = 1'b0;
                    oq_cancel_next = 1'b0;
                    oq_place_next = PLACE_W'(f_slot_reg);
                    ret_next = S_UL_REL;
                    st_next = S_OSCAN;
                end
            end
            S_UL_REL:
            begin
                ul_res_next = ST_OK;
                mw_en = 1'b1;
                if (ob_hit_reg)
                begin
                    mw_data = '{used: 1'b1, key: f_key_reg, holder: p_proc};
                    pclr[ob_idx_reg] = 1'b1;
                    em_dest_next = p_proc;
                    em_st_next = ST_OK;
                    em_ret_next = ul_post;
                    st_next = S_EMIT;
                end
                else
                begin
                    mw_data = '{used: 1'b0, key: f_key_reg, holder: f_holder_reg};
                    st_next = ul_post;
                end
            end
            S_K1_POST:
            begin
                em_dest_next = proc_reg;
                em_st_next = ul_res_reg;
                em_ret_next = S_FIN;
                st_next = S_EMIT;
            end
            S_K2_POST:
            begin
                if (ul_res_reg != ST_OK)
                begin
                    em_dest_next = proc_reg;
                    em_st_next = ST_INVALID;
                    em_ret_next = S_FIN;
                    st_next = S_EMIT;
                end
                else
                begin
                    cs_ptr_next = '0;
                    c_found_next = 1'b0;
                    st_next = S_CS_RD;
                end
            end
            S_CS_RD:
            begin
                cr_en = 1'b1;
                st_next = S_CS_CHK;
            end
            S_CS_CHK:
            begin
                if (cuse_reg[cs_ptr_reg] && crd_reg == ckey_reg)
                begin
                    c_found_next = 1'b1;
                    c_idx_next = cs_ptr_reg;
                    st_next = (kind_reg == KIND_WAIT) ? S_K2_COND : S_K3_START;
                end
                else if (cs_ptr_reg == COND_LAST)
                begin
                    st_next = (kind_reg == KIND_WAIT) ? S_K2_COND : S_K3_START;
                end
                else
                begin
                    cs_ptr_next = cs_ptr_reg + 1'b1;
                    st_next = S_CS_RD;
                end
            end
            S_K2_COND:
            begin
                em_dest_next = proc_reg;
                em_ret_next = S_FIN;
                if (!c_found_reg && !cf_vld)
                begin
                    em_st_next = ST_INVALID;
                    st_next = S_EMIT;
                end
                else if (!pf_vld)
                begin
                    em_st_next = ST_NO_ROOM;
                    st_next = S_EMIT;
                end
                else
                begin
                    if (!c_found_reg)
                    begin
                        cuse_next[cf_idx] = 1'b1;
                        cw_en = 1'b1;
                        cw_addr = cf_idx;
                    end
                    pool_put = 1'b1;
                    put_place = COND_BASE + PLACE_W'(c_found_reg ? c_idx_reg : cf_idx);
                    count_next = count_reg + 1'b1;
                    st_next = S_FIN;
                end
            end
            S_K3_START:
            begin
                if (c_found_reg)
                begin
                    st_next = S_K3_LOOP;
                end
                else
                begin
                    em_dest_next = proc_reg;
                    em_st_next = ST_OK;
                    em_ret_next = S_FIN;
                    st_next = S_EMIT;
                end
            end
            S_K3_LOOP:
            begin
                op_ptr_next = '0;
                ob_hit_next = 1'b0;
                oq_cancel_next = 1'b0;
                oq_place_next = COND_BASE + PLACE_W'(c_idx_reg);
                ret_next = S_K3_GOT;
                st_next = S_OSCAN;
            end
            S_K3_GOT:
            begin
                if (ob_hit_reg)
                begin
                    lk_proc_next = p_proc;
                    lk_key_next = pool_lock_reg[ob_idx_reg];
                    reuse_vld_next = 1'b1;
                    reuse_idx_next = ob_idx_reg;
                    sc_ctr_next = '0;
                    chk_vld_next = 1'b0;
                    f_hit_next = 1'b0;
                    f_free_vld_next = 1'b0;
                    sc_holder_next = 1'b0;
                    ret_next = S_LK_EVAL;
                    lk_ret_next = S_K3_POST;
                    st_next = S_SCAN;
                end
                else
                begin
                    cuse_next[c_idx_reg] = 1'b0;
                    em_dest_next = proc_reg;
                    em_st_next = ST_OK;
                    em_ret_next = S_FIN;
                    st_next = S_EMIT;
                end
            end
            S_K3_POST:
            begin
                if (lk_res_reg == ST_OK)
                begin
                    em_dest_next = lk_proc_reg;
                    em_st_next = ST_OK;
                    em_ret_next = S_K3_LOOP;
                    st_next = S_EMIT;
                end
                else
                begin
                    st_next = S_K3_LOOP;
                end
            end
            S_K4_POOL:
            begin
                pclr = pm_cancel;
                hit_next = f_hit_reg || (|pm_cancel);
                op_ptr_next = '0;
                ob_hit_next = 1'b0;
                oq_cancel_next = 1'b1;
                ret_next = S_K4_PARK;
                st_next = S_OSCAN;
            end
            S_K4_PARK:
            begin
                if (ob_hit_reg)
                begin
                    pclr[ob_idx_reg] = 1'b1;
                    hit_next = 1'b1;
                end
                op_ptr_next = '0;
                sw_mask_next = '0;
                st_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (p_v && p_place >= COND_BASE)
                begin
                    sw_mask_next[place_off[COND_W-1:0]] = 1'b1;
                end
                op_ptr_next = op_ptr_reg + 1'b1;
                if (op_ptr_reg == POOL_LAST)
                begin
                    cuse_next = cuse_reg & sw_mask_next;
                    if (kind_reg == KIND_CANCEL)
                    begin
                        st_next = S_K4_POST;
                    end
                    else
                    begin
                        sc_ctr_next = '0;
                        chk_vld_next = 1'b0;
                        f_hit_next = 1'b0;
                        sc_holder_next = 1'b1;
                        ret_next = S_EX_HIT;
                        st_next = S_SCAN;
                    end
                end
            end
            S_K4_POST:
            begin
                if (hit_reg)
                begin
                    em_dest_next = proc_reg;
                    em_st_next = ST_INTERRUPTED;
                    em_ret_next = S_FIN;
                    st_next = S_EMIT;
                end
                else
                begin
                    st_next = S_FIN;
                end
            end
            S_EX_HIT:
            begin
                if (f_hit_reg)
                begin
                    op_ptr_next = '0;
                    ob_hit_next = 1'b0;
                    oq_cancel_next = 1'b0;
                    oq_place_next = PLACE_W'(f_slot_reg);
                    ret_next = S_UL_REL;
                    st_next = S_OSCAN;
                end
                else
                begin
                    st_next = S_FIN;
                end
            end
            S_EX_NEXT:
            begin
                if (f_slot_reg == SLOT_LAST)
                begin
                    st_next = S_FIN;
                end
                else
                begin
                    sc_ctr_next = SLOT_CW'(f_slot_reg) + 1'b1;
                    chk_vld_next = 1'b0;
                    f_hit_next = 1'b0;
                    ret_next = S_EX_HIT;
                    st_next = S_SCAN;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            out_vld_next = 1'b1;
            out_next = '{dest_process: pend_dest_reg, status: pend_st_reg, last: push_last};
        end
        pv_next = pv_reg & ~pclr;
        if (pool_put)
        begin
            pv_next[put_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            mtab[mw_addr] <= mw_data;
        end
        if (mr_en)
        begin
            mrd_reg <= mtab[sc_ctr_reg[SLOT_W-1:0]];
        end
        if (cw_en)
        begin
            ctab[cw_addr] <= ckey_reg;
        end
        if (cr_en)
        begin
            crd_reg <= ctab[cs_ptr_reg];
        end
        if (pool_put)
        begin
            pool_proc_reg[put_idx] <= put_proc;
            pool_lock_reg[put_idx] <= put_lock;
            pool_place_reg[put_idx] <= put_place;
            pool_stamp_reg[put_idx] <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR;
            sc_ctr_reg <= '0;
            chk_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            pv_reg <= '0;
            cuse_reg <= '0;
            count_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            sc_ctr_reg <= sc_ctr_next;
            chk_vld_reg <= chk_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg <= out_vld_next;
            pv_reg <= pv_next;
            cuse_reg <= cuse_next;
            count_reg <= count_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next; lk_ret_reg <= lk_ret_next; em_ret_reg <= em_ret_next;
        kind_reg <= kind_next; proc_reg <= proc_next; mkey_reg <= mkey_next;
        ckey_reg <= ckey_next; lk_proc_reg <= lk_proc_next; lk_key_reg <= lk_key_next;
        reuse_vld_reg <= reuse_vld_next; reuse_idx_reg <= reuse_idx_next;
        lk_res_reg <= lk_res_next; ul_res_reg <= ul_res_next;
        f_hit_reg <= f_hit_next; f_free_vld_reg <= f_free_vld_next;
        f_slot_reg <= f_slot_next; f_free_reg <= f_free_next; f_key_reg <= f_key_next;
        f_holder_reg <= f_holder_next; sc_holder_reg <= sc_holder_next;
        chk_addr_reg <= chk_addr_next; op_ptr_reg <= op_ptr_next; ob_idx_reg <= ob_idx_next;
        ob_hit_reg <= ob_hit_next; oq_cancel_reg <= oq_cancel_next;
        ob_place_reg <= ob_place_next; oq_place_reg <= oq_place_next;
        ob_age_reg <= ob_age_next; cs_ptr_reg <= cs_ptr_next; c_idx_reg <= c_idx_next;
        c_found_reg <= c_found_next; hit_reg <= hit_next; sw_mask_reg <= sw_mask_next;
        em_dest_reg <= em_dest_next; em_st_reg <= em_st_next;
        pend_dest_reg <= pend_dest_next; pend_st_reg <= pend_st_next;
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> n_reg != '0)
        else $error("A held result was not counted.");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(RESULT_CAP))
        else $error("Result count exceeds the cap.");
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_IDLE |-> !pend_vld_reg)
        else $error("A result is left behind after a request.");
    a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> st_reg == S_SCAN)
        else $error("A table read is in flight outside a scan.");
`endif

endmodule

@@ tb/tb_mutex_condvar_lock_manager.sv @@
// ----------------------------------------------------------------------------
// tb_mutex_condvar_lock_manager
// Self-checking bench for the mutex and condition lock manager.
// ----------------------------------------------------------------------------
// Requests are driven as words on the req channel. A scoreboard keeps its own
// copy of the mutex table, the condition table and the waiter pool, and
// predicts the replies and grants of each accepted request. Every reply word
// is checked field by field, in order. A directed run covers the special
// cases, then random request mixes over a few processes and keys run with
// random idle bursts on both channels and one long hold-off on the replies.
// ----------------------------------------------------------------------------
module tb_mutex_condvar_lock_manager;
    import mclm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_BAD_LO = 3'd6;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int RANDOM_ITEMS = 190;

    class lock_scoreboard;
        bit          slot_used   [MUTEX_SLOTS];
        bit [31:0]   slot_key    [MUTEX_SLOTS];
        bit [15:0]   slot_holder [MUTEX_SLOTS];
        bit          cond_used   [COND_SLOTS];
        bit [31:0]   cond_id     [COND_SLOTS];
        bit          pool_used   [WAITER_POOL];
        bit [15:0]   pool_proc   [WAITER_POOL];
        bit [31:0]   pool_key    [WAITER_POOL];
        int          pool_place  [WAITER_POOL];
        bit [31:0]   pool_stamp  [WAITER_POOL];
        bit [31:0]   arrivals;
        mclm_rsp_t   replies_due [$];
        mclm_rsp_t   item_words  [$];
        int          errors;

        function void emit(bit [15:0] dest, logic [2:0] status);
            mclm_rsp_t w;
            if (item_words.size() < RESULT_CAP)
            begin
                w.dest_process = dest;
                w.status = status;
                w.last = 1'b0;
                item_words.push_back(w);
            end
        endfunction

        function int oldest(int place, bit by_proc, bit [15:0] proc);
            int best;
            bit [31:0] best_age;
            bit [31:0] age;
            best = -1;
            best_age = 0;
            for (int w = 0; w < WAITER_POOL; w++)
            begin
                if (!pool_used[w] || pool_place[w] != place) continue;
                if (by_proc && pool_proc[w] != proc) continue;
                age = arrivals - pool_stamp[w];
                if (best < 0 || age > best_age)
                begin
                    best = w;
                    best_age = age;
                end
            end
            return best;
        endfunction

        function int free_entry();
            for (int w = 0; w < WAITER_POOL; w++)
                if (!pool_used[w]) return w;
            return -1;
        endfunction

        function int find_slot(bit [31:0] key);
            for (int s = 0; s < MUTEX_SLOTS; s++)
                if (slot_used[s] && slot_key[s] == key) return s;
            return -1;
        endfunction

        function void enqueue(int w, bit [15:0] proc, bit [31:0] key, int place);
            pool_used[w] = 1;
            pool_proc[w] = proc;
            pool_key[w] = key;
            pool_place[w] = place;
            pool_stamp[w] = arrivals;
            arrivals++;
        endfunction

        function logic [2:0] lock_attempt(bit [15:0] proc, bit [31:0] key, int reuse);
            int s;
            int w;
            s = find_slot(key);
            if (s >= 0)
            begin
                if (slot_holder[s] == proc)
                begin
                    if (reuse >= 0) pool_used[reuse] = 0;
                    return ST_INVALID;
                end
                w = reuse >= 0 ? reuse : free_entry();
                if (w < 0) return ST_NO_ROOM;
                enqueue(w, proc, key, s);
                return ST_QUEUED;
            end
            if (reuse >= 0) pool_used[reuse] = 0;
            for (s = 0; s < MUTEX_SLOTS; s++)
            begin
                if (!slot_used[s])
                begin
                    slot_used[s] = 1;
                    slot_key[s] = key;
                    slot_holder[s] = proc;
                    return ST_OK;
                end
            end
            return ST_INVALID;
        endfunction

        function void release_slot(int s);
            int w;
            w = oldest(s, 0, 0);
            if (w >= 0)
            begin
                slot_holder[s] = pool_proc[w];
                pool_used[w] = 0;
                emit(slot_holder[s], ST_OK);
            end
            else
                slot_used[s] = 0;
        endfunction

        function logic [2:0] unlock_attempt(bit [15:0] proc, bit [31:0] key);
            int s;
            s = find_slot(key);
            if (s < 0 || slot_holder[s] != proc) return ST_NOT_PERMITTED;
            release_slot(s);
            return ST_OK;
        endfunction

        function void sweep_conds();
            for (int c = 0; c < COND_SLOTS; c++)
                if (cond_used[c] && oldest(MUTEX_SLOTS + c, 0, 0) < 0) cond_used[c] = 0;
        endfunction

        function void note_request(mclm_req_t r);
            bit [15:0]  proc;
            bit [31:0]  mkey;
            bit [31:0]  ckey;
            logic [2:0] st;
            int found;
            int freec;
            int target;
            int w;
            bit hit;
            bit [15:0] p;
            proc = r.process;
            mkey = r.mutex_key;
            ckey = r.cond_key;
            item_words.delete();
            case (r.kind)
                KIND_LOCK:
                begin
                    st = lock_attempt(proc, mkey, -1);
                    if (st != ST_QUEUED) emit(proc, st);
                end
                KIND_UNLOCK:
                begin
                    st = unlock_attempt(proc, mkey);
                    emit(proc, st);
                end
                KIND_WAIT:
                begin
                    if (unlock_attempt(proc, mkey) != ST_OK)
                        emit(proc, ST_INVALID);
                    else
                    begin
                        found = -1;
                        freec = -1;
                        for (int c = 0; c < COND_SLOTS; c++)
                        begin
                            if (cond_used[c] && cond_id[c] == ckey)
                            begin
                                found = c;
                                break;
                            end
                            if (!cond_used[c] && freec < 0) freec = c;
                        end
                        target = found >= 0 ? found : freec;
                        w = free_entry();
                        if (target < 0)
                            emit(proc, ST_INVALID);
                        else if (w < 0)
                            emit(proc, ST_NO_ROOM);
                        else
                        begin
                            if (found < 0)
                            begin
                                cond_used[target] = 1;
                                cond_id[target] = ckey;
                            end
                            enqueue(w, proc, mkey, MUTEX_SLOTS + target);
                        end
                    end
                end
                KIND_BROADCAST:
                begin
                    for (int c = 0; c < COND_SLOTS; c++)
                    begin
                        if (cond_used[c] && cond_id[c] == ckey)
                        begin
                            w = oldest(MUTEX_SLOTS + c, 0, 0);
                            while (w >= 0)
                            begin
                                p = pool_proc[w];
                                if (lock_attempt(p, pool_key[w], w) == ST_OK) emit(p, ST_OK);
                                w = oldest(MUTEX_SLOTS + c, 0, 0);
                            end
                            cond_used[c] = 0;
                            break;
                        end
                    end
                    emit(proc, ST_OK);
                end
                KIND_CANCEL:
                begin
                    hit = 0;
                    for (int s = 0; s < MUTEX_SLOTS; s++)
                        if (slot_used[s] && slot_holder[s] == proc) hit = 1;
                    for (int i = 0; i < WAITER_POOL; i++)
                    begin
                        if (pool_used[i] && pool_proc[i] == proc && pool_place[i] < MUTEX_SLOTS)
                        begin
                            pool_used[i] = 0;
                            hit = 1;
                        end
                    end
                    for (int c = 0; c < COND_SLOTS; c++)
                    begin
                        if (!cond_used[c]) continue;
                        w = oldest(MUTEX_SLOTS + c, 1, proc);
                        if (w >= 0)
                        begin
                            pool_used[w] = 0;
                            hit = 1;
                            break;
                        end
                    end
                    sweep_conds();
                    if (hit) emit(proc, ST_INTERRUPTED);
                end
                KIND_EXIT:
                begin
                    for (int i = 0; i < WAITER_POOL; i++)
                        if (pool_used[i] && pool_proc[i] == proc) pool_used[i] = 0;
                    sweep_conds();
                    for (int s = 0; s < MUTEX_SLOTS; s++)
                        if (slot_used[s] && slot_holder[s] == proc) release_slot(s);
                end
                default:
                    emit(proc, ST_INVALID);
            endcase
            if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
            foreach (item_words[i]) replies_due.push_back(item_words[i]);
        endfunction

        function void check_reply(mclm_rsp_t a);
            mclm_rsp_t e;
            if (replies_due.size() == 0)
            begin
                $error("unexpected reply word: dest_process %0d status %0d last %0d",
                       a.dest_process, a.status, a.last);
                errors++;
                return;
            end
            e = replies_due.pop_front();
            if (a.dest_process !== e.dest_process)
            begin
                $error("dest_process: expected %0d, actual %0d", e.dest_process, a.dest_process);
                errors++;
            end
            if (a.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, a.status);
                errors++;
            end
            if (a.last !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    mclm_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    mclm_rsp_t rsp;

    lock_scoreboard sb = new();
    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;

    bit [15:0] proc_set [6] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF};
    bit [31:0] mkey_set [5] = '{32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5};
    bit [31:0] ckey_set [4] = '{32'd0, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF};

    mutex_condvar_lock_manager uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall) sb.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall) sb.check_reply(rsp);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** mutex_condvar_lock_manager: FAILED **");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic send_word(logic [2:0] kind, bit [15:0] proc, bit [31:0] mkey,
                             bit [31:0] ckey);
        mclm_req_t w;
        w.kind = kind;
        w.process = proc;
        w.mutex_key = mkey;
        w.cond_key = ckey;
        req <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    function automatic bit [15:0] pick_proc();
        return ($urandom_range(0, 15) == 0) ? 16'($urandom) : proc_set[$urandom_range(0, 5)];
    endfunction

    function automatic bit [31:0] pick_mkey();
        return ($urandom_range(0, 15) == 0) ? $urandom : mkey_set[$urandom_range(0, 4)];
    endfunction

    function automatic bit [31:0] pick_ckey();
        return ($urandom_range(0, 15) == 0) ? $urandom : ckey_set[$urandom_range(0, 3)];
    endfunction

    task automatic send_random();
        int roll;
        logic [2:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 38) kind = KIND_LOCK;
        else if (roll < 58) kind = KIND_UNLOCK;
        else if (roll < 74) kind = KIND_WAIT;
        else if (roll < 84) kind = KIND_BROADCAST;
        else if (roll < 91) kind = KIND_CANCEL;
        else if (roll < 96) kind = KIND_EXIT;
        else kind = roll[0] ? KIND_BAD_LO : KIND_BAD_HI;
        send_word(kind, pick_proc(), pick_mkey(), pick_ckey());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_word(KIND_LOCK,      16'd0,     32'h8000_0000, 32'd0);
        send_word(KIND_LOCK,      16'd0,     32'h8000_0000, 32'd0);
        send_word(KIND_LOCK,      16'hFFFF,  32'h8000_0000, 32'd0);
        send_word(KIND_LOCK,      16'd1,     32'h8000_0000, 32'd0);
        send_word(KIND_UNLOCK,    16'd5,     32'h8000_0000, 32'd0);
        send_word(KIND_UNLOCK,    16'd0,     32'h8000_0000, 32'd0);
        send_word(KIND_LOCK,      16'd2,     32'h7FFF_FFFF, 32'd0);
        send_word(KIND_WAIT,      16'hFFFF,  32'h8000_0000, 32'h7FFF_FFFF);
        send_word(KIND_WAIT,      16'd2,     32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(KIND_WAIT,      16'd3,     32'd9,         32'd1);
        send_word(KIND_BROADCAST, 16'd4,     32'd0,         32'h8000_0000);
        send_word(KIND_BROADCAST, 16'd4,     32'd0,         32'h7FFF_FFFF);
        send_word(KIND_CANCEL,    16'hFFFF,  32'd0,         32'd0);
        send_word(KIND_CANCEL,    16'd3,     32'd0,         32'd0);
        send_word(KIND_LOCK,      16'd3,     32'd1,         32'd0);
        send_word(KIND_WAIT,      16'd3,     32'd1,         32'd5);
        send_word(KIND_CANCEL,    16'd3,     32'd0,         32'd0);
        send_word(KIND_EXIT,      16'd1,     32'd0,         32'd0);
        send_word(KIND_EXIT,      16'd2,     32'd0,         32'd0);
        send_word(KIND_BAD_LO,    16'hFFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_BAD_HI,    16'd0,     32'd0,         32'd0);

        gaps_on = 1'b1;
        stalls_on = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60) hold_off = 1'b1;
            if (i == RANDOM_ITEMS - 40)
            begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            send_random();
        end
        req_valid <= 1'b0;

        while (sb.replies_due.size() != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (sb.errors == 0 && sb.replies_due.size() == 0)
            $display("** mutex_condvar_lock_manager: PASSED **");
        else
            $display("** mutex_condvar_lock_manager: FAILED **");
        $finish;
    end

endmodule
